/* hw/rtl/itep_pkg.sv */
// itep_pkg: shared types and widths for the timestamp-to-epoch parser.
// Used by the front, the queue and the back; depends on nothing.

package itep_pkg;

	// widths of the parsed fields and of the result
	localparam int YEAR_W  = 14;
	localparam int FIELD_W = 7;
	localparam int EPOCH_W = 39;

	// one parsed timestamp, handed from the front to the back
	typedef struct packed {
		logic               ok;
		logic [YEAR_W-1:0]  year;
		logic [FIELD_W-1:0] month;
		logic [FIELD_W-1:0] day;
		logic [FIELD_W-1:0] hour;
		logic [FIELD_W-1:0] minute;
		logic [FIELD_W-1:0] second;
		logic               off_neg;
		logic [FIELD_W-1:0] off_hours;
		logic [FIELD_W-1:0] off_minutes;
	} rec_t;

endpackage

/* hw/rtl/itep_front.sv */
// itep_front: character parser, one item per cycle while the queue is not full; builds
// one record per timestamp. Depends on itep_pkg; feeds itep_queue.

module itep_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                char_valid,
	output logic                char_ready,
	input  logic [7:0]          char_code,
	input  logic                end_of_string,
	input  logic                queue_full,
	output logic                push,
	output itep_pkg::rec_t      push_rec
);

	// parse phases
	localparam logic [4:0] PH_YEAR     = 5'd0;
	localparam logic [4:0] PH_DASH1    = 5'd1;
	localparam logic [4:0] PH_MONTH    = 5'd2;
	localparam logic [4:0] PH_DASH2    = 5'd3;
	localparam logic [4:0] PH_DAY      = 5'd4;
	localparam logic [4:0] PH_SEP      = 5'd5;
	localparam logic [4:0] PH_HOUR     = 5'd6;
	localparam logic [4:0] PH_COLON1   = 5'd7;
	localparam logic [4:0] PH_MINUTE   = 5'd8;
	localparam logic [4:0] PH_COLON2   = 5'd9;
	localparam logic [4:0] PH_SECOND   = 5'd10;
	localparam logic [4:0] PH_ZONE     = 5'd11;
	localparam logic [4:0] PH_FRAC     = 5'd12;
	localparam logic [4:0] PH_OFFH     = 5'd13;
	localparam logic [4:0] PH_OFFCOLON = 5'd14;
	localparam logic [4:0] PH_OFFM     = 5'd15;
	localparam logic [4:0] PH_DONE     = 5'd16;

	// outcome codes
	localparam logic [1:0] OUT_PARSING  = 2'd0;
	localparam logic [1:0] OUT_ACCEPTED = 2'd1;
	localparam logic [1:0] OUT_REFUSED  = 2'd2;

	// characters
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_T     = 8'h54;
	localparam logic [7:0] CH_Z     = 8'h5A;

	localparam int YW = itep_pkg::YEAR_W;
	localparam int FW = itep_pkg::FIELD_W;

	logic [4:0]    phase_q;
	logic [1:0]    cnt_q;
	logic [1:0]    outcome_q;
	logic [YW-1:0] year_q;
	logic [FW-1:0] month_q, day_q, hour_q, minute_q, second_q;
	logic          off_neg_q;
	logic [FW-1:0] off_hours_q, off_minutes_q;

	logic [4:0]    ph_n;
	logic [1:0]    cnt_n;
	logic [1:0]    out_n;
	logic [YW-1:0] year_n;
	logic [FW-1:0] month_n, day_n, hour_n, minute_n, second_n;
	logic          off_neg_n;
	logic [FW-1:0] off_hours_n, off_minutes_n;

	logic          is_dig;
	logic [3:0]    dig;
	logic [YW-1:0] acc_year;
	logic [FW-1:0] sel2;
	logic [FW-1:0] acc2;
	logic [4:0]    next2;
	logic          wr2;
	logic          zone_go;
	logic          accept;
	logic          fin_acc;

	assign char_ready = !queue_full;
	assign accept     = char_valid && char_ready;
	assign push       = accept && end_of_string;

	// digit decode and accumulation
	assign is_dig   = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
	assign dig      = 4'(char_code - CH_ZERO);
	assign acc_year = YW'(year_q * YW'(10)) + YW'(dig);
	assign acc2     = FW'(sel2 * FW'(10)) + FW'(dig);

	// two-digit field select and the phase that follows it
	always_comb begin
		sel2  = off_minutes_q;
		next2 = PH_DONE;
		unique case (phase_q)
			PH_MONTH: begin
				sel2  = month_q;
				next2 = PH_DASH2;
			end
			PH_DAY: begin
				sel2  = day_q;
				next2 = PH_SEP;
			end
			PH_HOUR: begin
				sel2  = hour_q;
				next2 = PH_COLON1;
			end
			PH_MINUTE: begin
				sel2  = minute_q;
				next2 = PH_COLON2;
			end
			PH_SECOND: begin
				sel2  = second_q;
				next2 = PH_ZONE;
			end
			PH_OFFH: begin
				sel2  = off_hours_q;
				next2 = PH_OFFCOLON;
			end
			default: begin
				sel2  = off_minutes_q;
				next2 = PH_DONE;
			end
		endcase
	end

	// next parse state for the current character
	always_comb begin
		ph_n          = phase_q;
		cnt_n         = cnt_q;
		out_n         = outcome_q;
		year_n        = year_q;
		month_n       = month_q;
		day_n         = day_q;
		hour_n        = hour_q;
		minute_n      = minute_q;
		second_n      = second_q;
		off_neg_n     = off_neg_q;
		off_hours_n   = off_hours_q;
		off_minutes_n = off_minutes_q;
		wr2           = 1'b0;
		zone_go       = 1'b0;

		if (outcome_q == OUT_PARSING) begin
			unique case (phase_q) inside
				PH_YEAR: begin
					if (!is_dig) begin
						out_n = OUT_REFUSED;
						ph_n  = PH_DONE;
					end else begin
						year_n = acc_year;
						if (cnt_q == 2'd3) begin
							cnt_n = 2'd0;
							ph_n  = PH_DASH1;
						end else begin
							cnt_n = cnt_q + 2'd1;
						end
					end
				end
				PH_MONTH, PH_DAY, PH_HOUR, PH_MINUTE, PH_SECOND, PH_OFFH: begin
					if (!is_dig) begin
						out_n = OUT_REFUSED;
						ph_n  = PH_DONE;
					end else begin
						wr2 = 1'b1;
						if (cnt_q == 2'd1) begin
							cnt_n = 2'd0;
							ph_n  = next2;
						end else begin
							cnt_n = cnt_q + 2'd1;
						end
					end
				end
				PH_DASH1: begin
					ph_n = (char_code == CH_DASH) ? PH_MONTH : PH_DONE;
					if (char_code != CH_DASH) out_n = OUT_REFUSED;
				end
				PH_DASH2: begin
					ph_n = (char_code == CH_DASH) ? PH_DAY : PH_DONE;
					if (char_code != CH_DASH) out_n = OUT_REFUSED;
				end
				PH_COLON1: begin
					ph_n = (char_code == CH_COLON) ? PH_MINUTE : PH_DONE;
					if (char_code != CH_COLON) out_n = OUT_REFUSED;
				end
				PH_COLON2: begin
					ph_n = (char_code == CH_COLON) ? PH_SECOND : PH_DONE;
					if (char_code != CH_COLON) out_n = OUT_REFUSED;
				end
				PH_SEP: begin
					if (char_code == CH_T || char_code == CH_SPACE) begin
						ph_n = PH_HOUR;
					end else begin
						out_n = OUT_REFUSED;
						ph_n  = PH_DONE;
					end
				end
				PH_ZONE: begin
					if (char_code == CH_DOT) ph_n = PH_FRAC;
					else zone_go = 1'b1;
				end
				PH_FRAC: begin
					if (!is_dig) zone_go = 1'b1;
				end
				PH_OFFCOLON: begin
					if (char_code == CH_COLON) begin
						cnt_n = 2'd0;
						ph_n  = PH_OFFM;
					end else if (!is_dig) begin
						out_n = OUT_REFUSED;
						ph_n  = PH_DONE;
					end else begin
						wr2   = 1'b1;
						cnt_n = 2'd1;
						ph_n  = PH_OFFM;
					end
				end
				PH_OFFM: begin
					if (!is_dig) begin
						out_n = OUT_REFUSED;
						ph_n  = PH_DONE;
					end else begin
						wr2 = 1'b1;
						if (cnt_q == 2'd1) begin
							cnt_n = 2'd0;
							out_n = OUT_ACCEPTED;
							ph_n  = PH_DONE;
						end else begin
							cnt_n = cnt_q + 2'd1;
						end
					end
				end
				default: begin
					ph_n = phase_q;
				end
			endcase
		end

		// zone designator after the seconds or the fraction
		if (zone_go) begin
			if (char_code == CH_Z || char_code == CH_NUL) begin
				out_n = OUT_ACCEPTED;
				ph_n  = PH_DONE;
			end else if (char_code == CH_PLUS || char_code == CH_DASH) begin
				off_neg_n = (char_code == CH_DASH);
				cnt_n     = 2'd0;
				ph_n      = PH_OFFH;
			end else begin
				out_n = OUT_REFUSED;
				ph_n  = PH_DONE;
			end
		end

		// write back the two-digit field
		if (wr2) begin
			unique case (phase_q)
				PH_MONTH:  month_n  = acc2;
				PH_DAY:    day_n    = acc2;
				PH_HOUR:   hour_n   = acc2;
				PH_MINUTE: minute_n = acc2;
				PH_SECOND: second_n = acc2;
				PH_OFFH:   off_hours_n = acc2;
				default:   off_minutes_n = acc2;
			endcase
		end
	end

	// end of text: only the zone or fraction phase may still finish cleanly
	assign fin_acc = (out_n == OUT_ACCEPTED) ||
		((out_n == OUT_PARSING) && (ph_n == PH_ZONE || ph_n == PH_FRAC));

	always_comb begin
		push_rec.ok          = fin_acc;
		push_rec.year        = year_n;
		push_rec.month       = month_n;
		push_rec.day         = day_n;
		push_rec.hour        = hour_n;
		push_rec.minute      = minute_n;
		push_rec.second      = second_n;
		push_rec.off_neg     = off_neg_n;
		push_rec.off_hours   = off_hours_n;
		push_rec.off_minutes = off_minutes_n;
	end

	// parse state registers, cleared after the last character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_YEAR;
			cnt_q         <= 2'd0;
			outcome_q     <= OUT_PARSING;
			year_q        <= '0;
			month_q       <= '0;
			day_q         <= '0;
			hour_q        <= '0;
			minute_q      <= '0;
			second_q      <= '0;
			off_neg_q     <= 1'b0;
			off_hours_q   <= '0;
			off_minutes_q <= '0;
		end else if (accept) begin
			if (end_of_string) begin
				phase_q       <= PH_YEAR;
				cnt_q         <= 2'd0;
				outcome_q     <= OUT_PARSING;
				year_q        <= '0;
				month_q       <= '0;
				day_q         <= '0;
				hour_q        <= '0;
				minute_q      <= '0;
				second_q      <= '0;
				off_neg_q     <= 1'b0;
				off_hours_q   <= '0;
				off_minutes_q <= '0;
			end else begin
				phase_q       <= ph_n;
				cnt_q         <= cnt_n;
				outcome_q     <= out_n;
				year_q        <= year_n;
				month_q       <= month_n;
				day_q         <= day_n;
				hour_q        <= hour_n;
				minute_q      <= minute_n;
				second_q      <= second_n;
				off_neg_q     <= off_neg_n;
				off_hours_q   <= off_hours_n;
				off_minutes_q <= off_minutes_n;
			end
		end
	end

endmodule

/* hw/rtl/itep_queue.sv */
// itep_queue: short record queue between the parse front and the conversion back.
// Depends on itep_pkg for the record type.

module itep_queue #(
	parameter int DEPTH = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  itep_pkg::rec_t push_rec,
	output logic           full,
	input  logic           pop,
	output logic           not_empty,
	output itep_pkg::rec_t head
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	itep_pkg::rec_t   slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == FULL_CNT);
	assign not_empty = (count_q != '0);
	assign head      = slot_q[rd_ptr_q];

	// record storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_rec;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

/* hw/rtl/itep_back.sv */
// itep_back: checks a parsed record and converts it to epoch seconds by days-from-civil.
// Depends on itep_pkg; reads records from itep_queue and drives the result register.

module itep_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                rec_valid,
	input  itep_pkg::rec_t                      rec,
	output logic                                pop,
	output logic                                result_valid,
	input  logic                                result_ready,
	output logic signed [itep_pkg::EPOCH_W-1:0] epoch_seconds,
	output logic                                accepted
);

	localparam int EW = itep_pkg::EPOCH_W;

	// sequencer steps
	localparam logic [2:0] ST_LOAD = 3'd0;
	localparam logic [2:0] ST_ERA  = 3'd1;
	localparam logic [2:0] ST_YOE  = 3'd2;
	localparam logic [2:0] ST_DOE  = 3'd3;
	localparam logic [2:0] ST_DAYS = 3'd4;
	localparam logic [2:0] ST_MUL  = 3'd5;
	localparam logic [2:0] ST_SUM  = 3'd6;

	// days before the first of each month, counted from March
	function automatic logic [8:0] month_base(input logic [3:0] mp);
		logic [8:0] base;
		case (mp)
			4'd0:    base = 9'd0;
			4'd1:    base = 9'd31;
			4'd2:    base = 9'd61;
			4'd3:    base = 9'd92;
			4'd4:    base = 9'd122;
			4'd5:    base = 9'd153;
			4'd6:    base = 9'd184;
			4'd7:    base = 9'd214;
			4'd8:    base = 9'd245;
			4'd9:    base = 9'd275;
			4'd10:   base = 9'd306;
			4'd11:   base = 9'd337;
			default: base = 9'd0;
		endcase
		return base;
	endfunction

	logic [2:0]           step_q;
	logic                 ok_q;
	logic [13:0]          v_q;
	logic [8:0]           doy_q;
	logic [18:0]          tod_q;
	logic [18:0]          off_q;
	logic                 neg_q;
	logic signed [20:0]   secs_q;
	logic [4:0]           era_q;
	logic [8:0]           yoe_q;
	logic [17:0]          doe_q;
	logic signed [23:0]   days_q;
	logic signed [EW-1:0] prod_q;
	logic                 res_valid_q;
	logic signed [EW-1:0] epoch_q;
	logic                 accepted_q;

	logic [12:0]          off_total;
	logic                 fields_ok;
	logic [3:0]           mp;
	logic [15:0]          era_prod;
	logic [13:0]          yoe_full;
	logic [1:0]           div100;
	logic signed [23:0]   days_c;
	logic signed [41:0]   prod_c;
	logic signed [EW-1:0] sum_c;
	logic                 out_free;

	assign pop           = (step_q == ST_LOAD) && rec_valid;
	assign out_free      = !res_valid_q || result_ready;
	assign result_valid  = res_valid_q;
	assign epoch_seconds = epoch_q;
	assign accepted      = accepted_q;

	// range checks on the record at the queue head
	assign off_total = 13'(13'(rec.off_hours) * 13'd60) + 13'(rec.off_minutes);
	assign fields_ok = rec.ok &&
		(rec.month >= 7'd1) && (rec.month <= 7'd12) &&
		(rec.day >= 7'd1) && (rec.day <= 7'd31) &&
		(rec.hour <= 7'd23) && (rec.minute <= 7'd59) && (rec.second <= 7'd60) &&
		(rec.off_minutes <= 7'd59) && (off_total <= 13'd840) &&
		!(rec.off_neg && (off_total > 13'd720));
	assign mp = (rec.month > 7'd2) ? 4'(rec.month - 7'd3) : 4'(rec.month + 7'd9);

	// era from the shifted year: floor(v / 400) as (v / 16) * 41 / 1024
	assign era_prod = 16'({6'd0, v_q[13:4]} * 16'd41);
	assign yoe_full = v_q - 14'({9'd0, era_q} * 14'd400);

	// century count within the era
	always_comb begin
		if (yoe_q >= 9'd300)      div100 = 2'd3;
		else if (yoe_q >= 9'd200) div100 = 2'd2;
		else if (yoe_q >= 9'd100) div100 = 2'd1;
		else                      div100 = 2'd0;
	end

	// era counts from one era before year zero, hence the extra era subtracted
	assign days_c = $signed({1'b0, 23'({18'd0, era_q} * 23'd146097)}) +
		$signed({6'd0, doe_q}) - $signed(24'd865565);
	assign prod_c = days_q * $signed(18'd86400);
	assign sum_c  = prod_q + EW'(secs_q);

	// conversion sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_LOAD;
		end else begin
			unique case (step_q)
				ST_LOAD: if (rec_valid) step_q <= ST_ERA;
				ST_ERA:  step_q <= ST_YOE;
				ST_YOE:  step_q <= ST_DOE;
				ST_DOE:  step_q <= ST_DAYS;
				ST_DAYS: step_q <= ST_MUL;
				ST_MUL:  step_q <= ST_SUM;
				ST_SUM:  if (out_free) step_q <= ST_LOAD;
				default: step_q <= ST_LOAD;
			endcase
		end
	end

	// working registers of the conversion
	always_ff @(posedge clk) begin
		unique case (step_q)
			ST_LOAD: begin
				ok_q  <= fields_ok;
				v_q   <= rec.year + 14'd400 - ((rec.month <= 7'd2) ? 14'd1 : 14'd0);
				doy_q <= month_base(mp) + 9'(rec.day) - 9'd1;
				tod_q <= 19'(19'(rec.hour) * 19'd3600) + 19'(19'(rec.minute) * 19'd60) +
					19'(rec.second);
				off_q <= 19'(19'(rec.off_hours) * 19'd3600) +
					19'(19'(rec.off_minutes) * 19'd60);
				neg_q <= rec.off_neg;
			end
			ST_ERA: begin
				era_q  <= era_prod[14:10];
				secs_q <= neg_q ? ($signed({2'b0, tod_q}) + $signed({2'b0, off_q}))
				                : ($signed({2'b0, tod_q}) - $signed({2'b0, off_q}));
			end
			ST_YOE: begin
				yoe_q <= yoe_full[8:0];
			end
			ST_DOE: begin
				doe_q <= 18'(18'(yoe_q) * 18'd365) + 18'(yoe_q[8:2]) - 18'(div100) +
					18'(doy_q);
			end
			ST_DAYS: begin
				days_q <= days_c;
			end
			ST_MUL: begin
				prod_q <= prod_c[EW-1:0];
			end
			default: begin
				prod_q <= prod_q;
			end
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if ((step_q == ST_SUM) && out_free) begin
			res_valid_q <= 1'b1;
		end else if (result_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((step_q == ST_SUM) && out_free) begin
			epoch_q    <= ok_q ? sum_c : '0;
			accepted_q <= ok_q;
		end
	end

endmodule

/* hw/rtl/iso8601_to_epoch_parser.sv */
// Timestamp text to Unix epoch seconds. The parse front takes one character item per cycle
// while the record queue is not full. The conversion sequencer in the back takes each record
// through its steps LOAD, ERA, YOE, DOE, DAYS, MUL and SUM, and takes no new record until
// SUM hands its result on; the record queue absorbs short timestamps meanwhile. Reset
// (arst_n low) clears parser, queue and result valid.

module iso8601_to_epoch_parser #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                char_valid,
	output logic                                char_ready,
	input  logic [7:0]                          char_code,
	input  logic                                end_of_string,
	output logic                                result_valid,
	input  logic                                result_ready,
	output logic signed [itep_pkg::EPOCH_W-1:0] epoch_seconds,
	output logic                                accepted
);

	logic           q_full;
	logic           q_push;
	logic           q_pop;
	logic           q_not_empty;
	itep_pkg::rec_t push_rec;
	itep_pkg::rec_t head_rec;

	// character parser
	itep_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.char_valid    (char_valid),
		.char_ready    (char_ready),
		.char_code     (char_code),
		.end_of_string (end_of_string),
		.queue_full    (q_full),
		.push          (q_push),
		.push_rec      (push_rec)
	);

	// record queue
	itep_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_rec  (push_rec),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head      (head_rec)
	);

	// validation and epoch conversion
	itep_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.rec_valid     (q_not_empty),
		.rec           (head_rec),
		.pop           (q_pop),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.epoch_seconds (epoch_seconds),
		.accepted      (accepted)
	);

endmodule

/* hw/rtl/itep_checker.sv */
// itep_checker: port-level checks on the timestamp parser's result channel.
// Depends on itep_pkg; bound to iso8601_to_epoch_parser at the end of this file.

module itep_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                result_valid,
	input  logic                                result_ready,
	input  logic signed [itep_pkg::EPOCH_W-1:0] epoch_seconds,
	input  logic                                accepted
);

	// a stalled result stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result dropped while stalled");

	// a stalled result keeps its payload
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> $stable(epoch_seconds) && $stable(accepted))
		else $error("result payload changed while stalled");

	// a refused timestamp reads as epoch zero
	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !accepted |-> epoch_seconds == '0)
		else $error("refused item with nonzero epoch");

	// an accepted epoch lies within four-digit years and legal offsets
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && accepted |->
			(epoch_seconds >= -39'sd62167269600) && (epoch_seconds <= 39'sd253402344000))
		else $error("accepted epoch out of range");

endmodule

bind iso8601_to_epoch_parser itep_checker u_itep_checker (.*);

/* test/iso8601_to_epoch_parser_test.sv */
`timescale 1ns / 100ps
// iso8601_to_epoch_parser_test: self-checking bench for the timestamp-to-epoch parser.
// Feeds character items with random flow control and checks every result against its
// typed table value or a character-level predictor. Depends on itep_pkg and iso8601_to_epoch_parser.

module iso8601_to_epoch_parser_test;

	localparam int EPOCH_W = itep_pkg::EPOCH_W;
	localparam int YEAR_W  = itep_pkg::YEAR_W;
	localparam int FIELD_W = itep_pkg::FIELD_W;

	// parser phases and outcomes of the predictor
	typedef enum logic [4:0] {
		PH_YEAR, PH_DASH1, PH_MONTH, PH_DASH2, PH_DAY, PH_SEP, PH_HOUR, PH_COLON1,
		PH_MINUTE, PH_COLON2, PH_SECOND, PH_ZONE, PH_FRAC, PH_OFFH, PH_OFFCOLON,
		PH_OFFM, PH_DONE
	} phase_t;
	typedef enum logic [1:0] {OUT_PARSING, OUT_ACCEPTED, OUT_REFUSED} outcome_t;
	typedef enum int {RX_OPEN, RX_HALF, RX_SPARSE, RX_TOGGLE} rx_mode_t;

	// character codes the grammar cares about
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_ZERO  = "0";
	localparam logic [7:0] CH_NINE  = "9";
	localparam logic [7:0] CH_DASH  = "-";
	localparam logic [7:0] CH_PLUS  = "+";
	localparam logic [7:0] CH_COLON = ":";
	localparam logic [7:0] CH_T     = "T";
	localparam logic [7:0] CH_SPACE = " ";
	localparam logic [7:0] CH_DOT   = ".";
	localparam logic [7:0] CH_Z     = "Z";

	typedef struct {
		logic signed [EPOCH_W-1:0] epoch;
		logic                      ok;
	} stamp_t;

	typedef struct {
		string  head;
		bit     nul;
		string  tail;
		bit     typed;
		longint epoch;
		bit     ok;
	} row_t;

	logic                      clk;
	logic                      arst_n;
	logic                      char_valid;
	logic                      char_ready;
	logic [7:0]                char_code;
	logic                      end_of_string;
	logic                      result_valid;
	logic                      result_ready;
	logic signed [EPOCH_W-1:0] epoch_seconds;
	logic                      accepted;

	iso8601_to_epoch_parser DUT (.*);

	// predictor state
	phase_t             cur_phase;
	logic [2:0]         cur_count;
	logic [YEAR_W-1:0]  cur_year;
	logic [FIELD_W-1:0] cur_month, cur_day, cur_hour, cur_minute, cur_second;
	logic               cur_off_neg;
	logic [FIELD_W-1:0] cur_off_hours, cur_off_minutes;
	outcome_t           cur_outcome;

	stamp_t     expected_stamps[$];
	logic [7:0] text_q[$];
	int         errors = 0;
	int         burst_left = 0;

	// directed timestamps; typed rows carry their result, the others go by the predictor
	row_t stamp_rows[$] = '{
		'{"1970-01-01T00:00:00Z", 0, "", 1, 0, 1},
		'{"0000-01-01T00:00:00+14:00", 0, "", 1, -64'sd62167269600, 1},
		'{"9999-12-31T23:59:60-12:00", 0, "", 1, 64'sd253402344000, 1},
		'{"2024-02-29 12:34:56.789Z", 0, "", 0, 0, 0},
		'{"2001-09-09T01:46:40", 0, "", 0, 0, 0},
		'{"2015-06-30T23:59:60.5", 0, "", 0, 0, 0},
		'{"2020-05-17T08:30:00+0530", 0, "", 0, 0, 0},
		'{"2024-13-01T00:00:00Z", 0, "", 1, 0, 0},
		'{"2024-01-32T00:00:00Z", 0, "", 1, 0, 0},
		'{"2024-01-01T24:00:00Z", 0, "", 1, 0, 0},
		'{"2024-01-01T00:60:00Z", 0, "", 1, 0, 0},
		'{"2024-01-01T00:00:61Z", 0, "", 1, 0, 0},
		'{"2024-01-01T00:00:00+00:60", 0, "", 1, 0, 0},
		'{"2024-01-01T00:00:00+14:01", 0, "", 1, 0, 0},
		'{"2024-01-01T00:00:00-12:01", 0, "", 1, 0, 0},
		'{"2024/01", 0, "", 1, 0, 0},
		'{"2O24", 0, "", 1, 0, 0},
		'{"2024-01-01X", 0, "", 1, 0, 0},
		'{"2024-01-01T00:00:00Q", 0, "", 1, 0, 0},
		'{"2024-01-01T00:00:00+05", 0, "", 1, 0, 0},
		'{"2024-01-01T00:00:00+05:3", 0, "", 1, 0, 0},
		'{"2024-01", 0, "", 1, 0, 0},
		'{"2024-01-01T00:00:00Zjunk", 0, "", 0, 0, 0},
		'{"2024-01-01T06:07:08", 1, "xyz", 0, 0, 0},
		'{"2024-03-01T00:00:00.25", 1, "", 0, 0, 0}
	};

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// ---------------- predictor ----------------

	function automatic void clear_parse();
		cur_phase       = PH_YEAR;
		cur_count       = '0;
		cur_year        = '0;
		cur_month       = '0;
		cur_day         = '0;
		cur_hour        = '0;
		cur_minute      = '0;
		cur_second      = '0;
		cur_off_neg     = 1'b0;
		cur_off_hours   = '0;
		cur_off_minutes = '0;
		cur_outcome     = OUT_PARSING;
	endfunction

	function automatic void close_parse(outcome_t how);
		cur_outcome = how;
		cur_phase   = PH_DONE;
	endfunction

	function automatic bit is_digit(logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	// counts one digit, moves on when the field is full; the caller folds in the value
	function automatic bit take_digit(logic [7:0] c, int need, phase_t nxt);
		if (!is_digit(c)) begin
			close_parse(OUT_REFUSED);
			return 1'b0;
		end
		cur_count++;
		if (int'(cur_count) >= need) begin
			cur_count = '0;
			cur_phase = nxt;
		end
		return 1'b1;
	endfunction

	function automatic logic [FIELD_W-1:0] add_digit(logic [FIELD_W-1:0] f, logic [7:0] c);
		return FIELD_W'(int'(f) * 10 + int'(c - CH_ZERO));
	endfunction

	function automatic void zone_start(logic [7:0] c);
		if (c == CH_Z || c == CH_NUL) begin
			close_parse(OUT_ACCEPTED);
		end else if (c == CH_PLUS || c == CH_DASH) begin
			cur_off_neg = (c == CH_DASH);
			cur_count   = '0;
			cur_phase   = PH_OFFH;
		end else begin
			close_parse(OUT_REFUSED);
		end
	endfunction

	function automatic void feed_char(logic [7:0] c);
		case (cur_phase)
			PH_YEAR: begin
				if (take_digit(c, 4, PH_DASH1))
					cur_year = YEAR_W'(int'(cur_year) * 10 + int'(c - CH_ZERO));
			end
			PH_DASH1: begin
				if (c == CH_DASH) cur_phase = PH_MONTH;
				else close_parse(OUT_REFUSED);
			end
			PH_MONTH: begin
				if (take_digit(c, 2, PH_DASH2)) cur_month = add_digit(cur_month, c);
			end
			PH_DASH2: begin
				if (c == CH_DASH) cur_phase = PH_DAY;
				else close_parse(OUT_REFUSED);
			end
			PH_DAY: begin
				if (take_digit(c, 2, PH_SEP)) cur_day = add_digit(cur_day, c);
			end
			PH_SEP: begin
				if (c == CH_T || c == CH_SPACE) cur_phase = PH_HOUR;
				else close_parse(OUT_REFUSED);
			end
			PH_HOUR: begin
				if (take_digit(c, 2, PH_COLON1)) cur_hour = add_digit(cur_hour, c);
			end
			PH_COLON1: begin
				if (c == CH_COLON) cur_phase = PH_MINUTE;
				else close_parse(OUT_REFUSED);
			end
			PH_MINUTE: begin
				if (take_digit(c, 2, PH_COLON2)) cur_minute = add_digit(cur_minute, c);
			end
			PH_COLON2: begin
				if (c == CH_COLON) cur_phase = PH_SECOND;
				else close_parse(OUT_REFUSED);
			end
			PH_SECOND: begin
				if (take_digit(c, 2, PH_ZONE)) cur_second = add_digit(cur_second, c);
			end
			PH_ZONE: begin
				if (c == CH_DOT) cur_phase = PH_FRAC;
				else zone_start(c);
			end
			PH_FRAC: begin
				if (!is_digit(c)) zone_start(c);
			end
			PH_OFFH: begin
				if (take_digit(c, 2, PH_OFFCOLON)) cur_off_hours = add_digit(cur_off_hours, c);
			end
			PH_OFFCOLON: begin
				cur_count = '0;
				if (c == CH_COLON) begin
					cur_phase = PH_OFFM;
				end else begin
					// colon left out: this is already the first minute digit
					if (take_digit(c, 2, PH_DONE))
						cur_off_minutes = add_digit(cur_off_minutes, c);
					if (cur_outcome == OUT_PARSING) cur_phase = PH_OFFM;
				end
			end
			PH_OFFM: begin
				if (take_digit(c, 2, PH_OFFM))
					cur_off_minutes = add_digit(cur_off_minutes, c);
				if (cur_outcome == OUT_PARSING && cur_count == 0) close_parse(OUT_ACCEPTED);
			end
			default: begin
			end
		endcase
	endfunction

	function automatic longint civil_day_count(longint y, longint m, longint d);
		longint era, yoe, doy, doe;
		if (m <= 2) y -= 1;
		era = (y >= 0 ? y : y - 399) / 400;
		yoe = y - era * 400;
		doy = (153 * (m + (m > 2 ? -3 : 9)) + 2) / 5 + d - 1;
		doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
		return era * 146097 + doe - 719468;
	endfunction

	function automatic bit fields_in_range();
		int total;
		total = int'(cur_off_hours) * 60 + int'(cur_off_minutes);
		if (cur_month < 1 || cur_month > 12) return 1'b0;
		if (cur_day < 1 || cur_day > 31) return 1'b0;
		if (cur_hour > 23 || cur_minute > 59 || cur_second > 60) return 1'b0;
		if (cur_off_minutes > 59) return 1'b0;
		if (total > 14 * 60) return 1'b0;
		if (cur_off_neg && total > 12 * 60) return 1'b0;
		return 1'b1;
	endfunction

	// one accepted character; a result only when it carries end_of_string
	function automatic void predict_char(input logic [7:0] c, input logic last,
			output bit has, output stamp_t r);
		longint off, ep;
		has = 1'b0;
		r   = '{epoch: '0, ok: 1'b0};
		if (cur_outcome == OUT_PARSING) feed_char(c);
		if (!last) return;
		if (cur_outcome == OUT_PARSING) feed_char(CH_NUL);
		has = 1'b1;
		if (cur_outcome == OUT_ACCEPTED && fields_in_range()) begin
			off = longint'(cur_off_hours) * 3600 + longint'(cur_off_minutes) * 60;
			ep = civil_day_count(longint'(cur_year), longint'(cur_month),
				longint'(cur_day)) * 86400
				+ longint'(cur_hour) * 3600 + longint'(cur_minute) * 60
				+ longint'(cur_second);
			ep = cur_off_neg ? ep + off : ep - off;
			r.epoch = ep[EPOCH_W-1:0];
			r.ok    = 1'b1;
		end
		clear_parse();
	endfunction

	// ---------------- stimulus helpers ----------------

	function automatic void push_digits(int value, int n);
		int div;
		div = 1;
		repeat (n - 1) div *= 10;
		repeat (n) begin
			text_q.push_back(8'(int'(CH_ZERO) + (value / div) % 10));
			div /= 10;
		end
	endfunction

	// offers the characters of text_q as items, end_of_string on the last one
	task automatic send_text(input bit typed, input stamp_t typed_val);
		int     gap;
		bit     has;
		stamp_t r;
		for (int i = 0; i < text_q.size(); i++) begin
			// bursts of back-to-back items with random gaps between them
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 40);
				gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
				if (gap > 0) begin
					char_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			burst_left--;
			char_valid    <= 1'b1;
			char_code     <= text_q[i];
			end_of_string <= (i == text_q.size() - 1);
			@(posedge clk);
			while (!char_ready) @(posedge clk);
			predict_char(text_q[i], i == text_q.size() - 1, has, r);
			if (has) expected_stamps.push_back(typed ? typed_val : r);
		end
	endtask

	// ---------------- stimulus ----------------

	initial begin : stimulus
		int     rand_items;
		int     kind, sel, yr, mon, dy, hr, mi, se, zone, n;
		stamp_t typed_val;
		char_valid    = 1'b0;
		char_code     = '0;
		end_of_string = 1'b0;
		arst_n        = 1'b0;
		clear_parse();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (stamp_rows[i]) begin
			text_q.delete();
			for (int k = 0; k < stamp_rows[i].head.len(); k++)
				text_q.push_back(stamp_rows[i].head[k]);
			if (stamp_rows[i].nul) text_q.push_back(CH_NUL);
			for (int k = 0; k < stamp_rows[i].tail.len(); k++)
				text_q.push_back(stamp_rows[i].tail[k]);
			typed_val.epoch = stamp_rows[i].epoch[EPOCH_W-1:0];
			typed_val.ok    = stamp_rows[i].ok;
			send_text(stamp_rows[i].typed, typed_val);
		end

		// random timestamps: mostly well-formed, some broken, some noise
		rand_items = 0;
		typed_val  = '{epoch: '0, ok: 1'b0};
		while (rand_items < 100) begin
			text_q.delete();
			kind = $urandom_range(0, 99);
			if (kind < 85) begin
				sel = $urandom_range(0, 9);
				yr  = (sel == 0) ? 0 : (sel == 1) ? 9999 :
					(sel == 2) ? $urandom_range(0, 9999) : $urandom_range(1900, 2100);
				mon = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 12);
				dy  = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 31);
				hr  = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 23);
				mi  = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 59);
				se  = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 60);
				push_digits(yr, 4);
				text_q.push_back(CH_DASH);
				push_digits(mon, 2);
				text_q.push_back(CH_DASH);
				push_digits(dy, 2);
				text_q.push_back($urandom_range(0, 1) ? CH_T : CH_SPACE);
				push_digits(hr, 2);
				text_q.push_back(CH_COLON);
				push_digits(mi, 2);
				text_q.push_back(CH_COLON);
				push_digits(se, 2);
				// optional fractional seconds
				if ($urandom_range(0, 3) == 0) begin
					text_q.push_back(CH_DOT);
					repeat ($urandom_range(0, 6)) push_digits($urandom_range(0, 9), 1);
				end
				zone = $urandom_range(0, 4);
				if (zone == 0) text_q.push_back(CH_Z);
				else if (zone == 1) text_q.push_back(CH_NUL);
				else if (zone >= 3) begin
					text_q.push_back($urandom_range(0, 1) ? CH_DASH : CH_PLUS);
					push_digits(($urandom_range(0, 7) == 0) ? $urandom_range(0, 99)
						: $urandom_range(0, 14), 2);
					if (zone == 3) text_q.push_back(CH_COLON);
					push_digits(($urandom_range(0, 7) == 0) ? $urandom_range(0, 99)
						: ($urandom_range(0, 1) ? 15 * $urandom_range(0, 3)
						: $urandom_range(0, 60)), 2);
				end
				// trailing text after a finished zone
				if (zone != 2 && $urandom_range(0, 2) == 0)
					repeat ($urandom_range(1, 4)) text_q.push_back(8'($urandom_range(0, 255)));
				// broken: cut short or one character replaced
				if (kind >= 70) begin
					if ($urandom_range(0, 1)) begin
						n = $urandom_range(1, text_q.size());
						while (text_q.size() > n) void'(text_q.pop_back());
					end else begin
						text_q[$urandom_range(0, text_q.size() - 1)] = 8'($urandom_range(0, 255));
					end
				end
			end else begin
				repeat ($urandom_range(1, 24)) text_q.push_back(8'($urandom_range(0, 255)));
			end
			rand_items += text_q.size();
			send_text(1'b0, typed_val);
		end
		char_valid    <= 1'b0;
		end_of_string <= 1'b0;

		// drain, then keep watching to catch stray results
		while (expected_stamps.size() > 0) @(posedge clk);
		repeat (24) @(posedge clk);
		if (errors == 0) begin
			$display("iso8601_to_epoch_parser verification clean");
		end else begin
			$display("iso8601_to_epoch_parser verification failed");
		end
		$finish;
	end

	// ---------------- receiver and checker ----------------

	initial begin : receiver
		int       cycle, seg_left;
		rx_mode_t mode;
		stamp_t   want;
		cycle        = 0;
		seg_left     = 0;
		mode         = RX_OPEN;
		result_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			// compare an accepted result with the oldest expectation
			if (result_valid && result_ready) begin
				if (expected_stamps.size() == 0) begin
					$error("unexpected result: epoch_seconds %0d accepted %0b",
						epoch_seconds, accepted);
					errors++;
				end else begin
					want = expected_stamps.pop_front();
					if (epoch_seconds !== want.epoch) begin
						$error("epoch_seconds: expected %0d actual %0d", want.epoch, epoch_seconds);
						errors++;
					end
					if (accepted !== want.ok) begin
						$error("accepted: expected %0b actual %0b", want.ok, accepted);
						errors++;
					end
				end
			end
			// stall pattern, with two long hold-offs that back up the input
			cycle++;
			if (seg_left == 0) begin
				seg_left = $urandom_range(10, 80);
				mode     = rx_mode_t'($urandom_range(0, 3));
			end
			seg_left--;
			if ((cycle >= 200 && cycle < 350) || (cycle >= 520 && cycle < 640)) begin
				result_ready <= 1'b0;
			end else begin
				case (mode)
					RX_OPEN:   result_ready <= 1'b1;
					RX_HALF:   result_ready <= 1'($urandom_range(0, 1));
					RX_SPARSE: result_ready <= ($urandom_range(0, 3) == 0);
					default:   result_ready <= cycle[0];
				endcase
			end
		end
	end

	// run limit
	initial begin
		#2_000_000;
		$display("iso8601_to_epoch_parser verification failed");
		$finish;
	end

endmodule

/* iso8601_to_epoch_parser.f */
hw/rtl/itep_pkg.sv
hw/rtl/itep_front.sv
hw/rtl/itep_queue.sv
hw/rtl/itep_back.sv
hw/rtl/iso8601_to_epoch_parser.sv
hw/rtl/itep_checker.sv
test/iso8601_to_epoch_parser_test.sv
